// ===== sv/modular_arithmetic_unit_assert.svh =====
// assertion macros for the modular arithmetic unit
`ifndef MODULAR_ARITHMETIC_UNIT_ASSERT_SVH
`define MODULAR_ARITHMETIC_UNIT_ASSERT_SVH

// implication checked every clock, quiet during reset
`define MAU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked every clock, quiet during reset
`define MAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/mau_pkg.sv =====
// shared constants, codes and types for the modular arithmetic unit
package mau_pkg;

   localparam int unsigned DATA_WIDTH_DEFAULT = 32;
   localparam int unsigned EXP_WIDTH          = 63;
   localparam int unsigned CMD_WIDTH          = 3;
   localparam longint unsigned MODULUS_RESET  = 64'd1000000007;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_POW = 3'd4,
      CMD_INC = 3'd5,
      CMD_DEC = 3'd6,
      CMD_CMP = 3'd7
   } cmd_type;

   // handshake between the sequencer and the serial multiplier
   typedef struct packed {
      logic start;
   } mul_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

endpackage

// ===== sv/mau_mulmod.sv =====
// bit-serial modular multiplier, one multiplier bit per cycle
module mau_mulmod #(
   parameter int unsigned DATA_WIDTH = mau_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mau_pkg::mul_ctrl_type   ctrl,
   input  logic [DATA_WIDTH-1:0]   mod_val,
   input  logic [DATA_WIDTH-1:0]   opa,
   input  logic [DATA_WIDTH-1:0]   opb,
   output mau_pkg::mul_stat_type   stat,
   output logic [DATA_WIDTH-1:0]   prod
);

   localparam int unsigned CW = $clog2(DATA_WIDTH + 1);

   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [DATA_WIDTH-1:0] a_ff, a_in;
   logic [DATA_WIDTH-1:0] b_ff, b_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DATA_WIDTH:0]   dbl, dbl_red, sum, sum_red;

   always_comb begin
      // acc = 2*acc mod m, then + a mod m when the top bit of b is set
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, mod_val}) ? dbl - {1'b0, mod_val} : dbl;
      sum     = dbl_red + {1'b0, a_ff};
      sum_red = (sum >= {1'b0, mod_val}) ? sum - {1'b0, mod_val} : sum;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         acc_in  = '0;
         a_in    = opa;
         b_in    = opb;
         cnt_in  = CW'(DATA_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = b_ff[DATA_WIDTH-1] ? sum_red[DATA_WIDTH-1:0] : dbl_red[DATA_WIDTH-1:0];
         b_in   = {b_ff[DATA_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign prod      = acc_ff;

endmodule

// ===== sv/mau_reduce.sv =====
// bit-serial restoring reduction of an operand modulo the modulus
module mau_reduce #(
   parameter int unsigned DATA_WIDTH = mau_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] mod_val,
   input  logic [DATA_WIDTH-1:0] value,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] rem
);

   localparam int unsigned CW = $clog2(DATA_WIDTH + 1);

   logic [DATA_WIDTH-1:0] r_ff, r_in;
   logic [DATA_WIDTH-1:0] v_ff, v_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DATA_WIDTH:0]   sh;

   always_comb begin
      // shift in one dividend bit, subtract the modulus when it fits
      sh      = {r_ff, v_ff[DATA_WIDTH-1]};
      r_in    = r_ff;
      v_in    = v_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         r_in    = '0;
         v_in    = value;
         cnt_in  = CW'(DATA_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in   = (sh >= {1'b0, mod_val}) ? DATA_WIDTH'(sh - {1'b0, mod_val})
                                          : sh[DATA_WIDTH-1:0];
         v_in   = {v_ff[DATA_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      r_ff <= r_in;
      v_ff <= v_in;
   end

   assign done = done_ff;
   assign rem  = r_ff;

endmodule

// ===== sv/modular_arithmetic_unit.sv =====
// top level of the modular arithmetic unit: sequencer, operand reduction, result register
//
//  channel   direction  ports                                  handshake
//  req       in         command operand_a operand_b exponent   req_valid / req_stall
//  rsp       out        result equal_flag less_flag divisor_zero  rsp_valid / rsp_stall
//  csr       in         modulus                                csr_write_enable, no wait
//
// one transaction at a time; operands a and b are reduced one after the other in the bit-serial reducer
// each modular multiply runs in the bit-serial multiplier,
//   with one ST_PSTEP step per exponent bit in pow and div
// pow costs up to 2*63 multiplies, div up to 2*DATA_WIDTH+1, mul one, others none
// synchronous active-high reset clears control and loads the modulus reset value
// a finished transaction waits in the rsp register while rsp_stall holds
module modular_arithmetic_unit #(
   parameter int unsigned DATA_WIDTH = mau_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [DATA_WIDTH-1:0]          csr_modulus,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [mau_pkg::CMD_WIDTH-1:0]  req_command,
   input  logic [DATA_WIDTH-1:0]          req_operand_a,
   input  logic [DATA_WIDTH-1:0]          req_operand_b,
   input  logic [mau_pkg::EXP_WIDTH-1:0]  req_exponent,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [DATA_WIDTH-1:0]          rsp_result,
   output logic                           rsp_equal_flag,
   output logic                           rsp_less_flag,
   output logic                           rsp_divisor_zero
);

`include "modular_arithmetic_unit_assert.svh"

   localparam int unsigned EW = mau_pkg::EXP_WIDTH;
   // exponent register wide enough for the exponent field or modulus-2
   localparam int unsigned XW = (EW > DATA_WIDTH) ? EW : DATA_WIDTH;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_RED_A  = 9'b000000010,
      ST_RED_B  = 9'b000000100,
      ST_EXEC   = 9'b000001000,
      ST_PSTEP  = 9'b000010000,
      ST_PMUL   = 9'b000100000,
      ST_PSQR   = 9'b001000000,
      ST_FMUL   = 9'b010000000,
      ST_OUT    = 9'b100000000
   } state_type;

   state_type              state_ff, state_in;
   logic [DATA_WIDTH-1:0]  modulus_ff;
   logic [DATA_WIDTH-1:0]  m_eff;
   mau_pkg::cmd_type       cmd_ff, cmd_in;
   logic [DATA_WIDTH-1:0]  a_ff, a_in, b_ff, b_in;
   logic [DATA_WIDTH-1:0]  acc_ff, acc_in, base_ff, base_in;
   logic [XW-1:0]          exp_ff, exp_in;
   logic [DATA_WIDTH-1:0]  raw_b_ff, raw_b_in;
   logic                   rv_ff, rv_in;
   logic [DATA_WIDTH-1:0]  res_ff, res_in;
   logic                   eq_ff, eq_in, lt_ff, lt_in, dz_ff, dz_in;
   // response register, apart from the working result
   logic [DATA_WIDTH-1:0]  out_res_ff, out_res_in;
   logic                   out_eq_ff, out_eq_in, out_lt_ff, out_lt_in, out_dz_ff, out_dz_in;

   logic                   red_start, red_done;
   logic [DATA_WIDTH-1:0]  red_value, red_rem;
   mau_pkg::mul_ctrl_type  mul_ctrl;
   mau_pkg::mul_stat_type  mul_stat;
   logic [DATA_WIDTH-1:0]  mul_a, mul_b, mul_p;

   logic                   req_fire, rsp_fire;
   logic [DATA_WIDTH:0]    sum_ab, sum_a1;
   logic [DATA_WIDTH-1:0]  one_mod;

   // a modulus of 0 or 1 behaves as modulus 1
   assign m_eff   = (modulus_ff < DATA_WIDTH'(2)) ? DATA_WIDTH'(1) : modulus_ff;
   assign one_mod = (m_eff == DATA_WIDTH'(1)) ? '0 : DATA_WIDTH'(1);

   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rv_ff && !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   mau_reduce #(.DATA_WIDTH(DATA_WIDTH)) u_reduce (
      .clock   (clock),
      .reset   (reset),
      .start   (red_start),
      .mod_val (m_eff),
      .value   (red_value),
      .done    (red_done),
      .rem     (red_rem)
   );

   mau_mulmod #(.DATA_WIDTH(DATA_WIDTH)) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mul_ctrl),
      .mod_val (m_eff),
      .opa     (mul_a),
      .opb     (mul_b),
      .stat    (mul_stat),
      .prod    (mul_p)
   );

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      acc_in    = acc_ff;
      base_in   = base_ff;
      exp_in    = exp_ff;
      raw_b_in  = raw_b_ff;
      rv_in     = rv_ff;
      res_in    = res_ff;
      eq_in     = eq_ff;
      lt_in     = lt_ff;
      dz_in     = dz_ff;
      out_res_in = out_res_ff;
      out_eq_in  = out_eq_ff;
      out_lt_in  = out_lt_ff;
      out_dz_in  = out_dz_ff;
      red_start = 1'b0;
      red_value = req_operand_a;
      mul_ctrl.start = 1'b0;
      mul_a     = a_ff;
      mul_b     = b_ff;
      sum_ab    = {1'b0, a_ff} + {1'b0, b_ff};
      sum_a1    = {1'b0, a_ff} + {1'b0, one_mod};

      if (rsp_fire) begin
         rv_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in    = mau_pkg::cmd_type'(req_command);
               raw_b_in  = req_operand_b;
               exp_in    = XW'(req_exponent);
               red_start = 1'b1;
               red_value = req_operand_a;
               state_in  = ST_RED_A;
            end
         end
         ST_RED_A: begin
            if (red_done) begin
               a_in      = red_rem;
               red_start = 1'b1;
               red_value = raw_b_ff;
               state_in  = ST_RED_B;
            end
         end
         ST_RED_B: begin
            if (red_done) begin
               b_in     = red_rem;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            eq_in = 1'b0;
            lt_in = 1'b0;
            dz_in = 1'b0;
            res_in = '0;
            state_in = ST_OUT;
            case (cmd_ff)
               mau_pkg::CMD_ADD: begin
                  res_in = (sum_ab >= {1'b0, m_eff}) ? DATA_WIDTH'(sum_ab - {1'b0, m_eff})
                                                      : sum_ab[DATA_WIDTH-1:0];
               end
               mau_pkg::CMD_SUB: begin
                  res_in = (a_ff >= b_ff) ? a_ff - b_ff : m_eff - b_ff + a_ff;
               end
               mau_pkg::CMD_MUL: begin
                  mul_ctrl.start = 1'b1;
                  state_in = ST_FMUL;
               end
               mau_pkg::CMD_DIV: begin
                  if (b_ff == '0) begin
                     dz_in = 1'b1;
                  end else begin
                     acc_in  = one_mod;
                     base_in = b_ff;
                     exp_in  = XW'(m_eff - DATA_WIDTH'(2));
                     state_in = ST_PSTEP;
                  end
               end
               mau_pkg::CMD_POW: begin
                  acc_in  = one_mod;
                  base_in = b_ff;
                  state_in = ST_PSTEP;
               end
               mau_pkg::CMD_INC: begin
                  res_in = (sum_a1 >= {1'b0, m_eff}) ? DATA_WIDTH'(sum_a1 - {1'b0, m_eff})
                                                      : sum_a1[DATA_WIDTH-1:0];
               end
               mau_pkg::CMD_DEC: begin
                  res_in = (a_ff == '0) ? m_eff - DATA_WIDTH'(1) : a_ff - DATA_WIDTH'(1);
               end
               default: begin
                  eq_in = (a_ff == b_ff);
                  lt_in = (a_ff < b_ff);
               end
            endcase
         end
         ST_PSTEP: begin
            // one exponent bit: multiply when set, then square; at exponent zero finish, div with a final multiply by a
            if (exp_ff == '0) begin
               if (cmd_ff == mau_pkg::CMD_DIV) begin
                  mul_ctrl.start = 1'b1;
                  mul_a = a_ff;
                  mul_b = acc_ff;
                  state_in = ST_FMUL;
               end else begin
                  res_in   = acc_ff;
                  state_in = ST_OUT;
               end
            end else if (exp_ff[0]) begin
               mul_ctrl.start = 1'b1;
               mul_a = acc_ff;
               mul_b = base_ff;
               state_in = ST_PMUL;
            end else begin
               mul_ctrl.start = 1'b1;
               mul_a = base_ff;
               mul_b = base_ff;
               state_in = ST_PSQR;
            end
         end
         ST_PMUL: begin
            if (mul_stat.done) begin
               acc_in = mul_p;
               mul_ctrl.start = 1'b1;
               mul_a = base_ff;
               mul_b = base_ff;
               state_in = ST_PSQR;
            end
         end
         ST_PSQR: begin
            if (mul_stat.done) begin
               base_in  = mul_p;
               exp_in   = exp_ff >> 1;
               state_in = ST_PSTEP;
            end
         end
         ST_FMUL: begin
            if (mul_stat.done) begin
               res_in   = mul_p;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // wait until the previous response has left the register
            if (!rv_ff || rsp_fire) begin
               rv_in      = 1'b1;
               out_res_in = res_ff;
               out_eq_in  = eq_ff;
               out_lt_in  = lt_ff;
               out_dz_in  = dz_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rv_ff      <= 1'b0;
         modulus_ff <= DATA_WIDTH'(mau_pkg::MODULUS_RESET);
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         if (csr_write_enable) begin
            modulus_ff <= csr_modulus;
         end
      end
      cmd_ff   <= cmd_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      acc_ff   <= acc_in;
      base_ff  <= base_in;
      exp_ff   <= exp_in;
      raw_b_ff <= raw_b_in;
      res_ff   <= res_in;
      eq_ff    <= eq_in;
      lt_ff    <= lt_in;
      dz_ff    <= dz_in;
      out_res_ff <= out_res_in;
      out_eq_ff  <= out_eq_in;
      out_lt_ff  <= out_lt_in;
      out_dz_ff  <= out_dz_in;
   end

   assign rsp_valid        = rv_ff;
   assign rsp_result       = out_res_ff;
   assign rsp_equal_flag   = out_eq_ff;
   assign rsp_less_flag    = out_lt_ff;
   assign rsp_divisor_zero = out_dz_ff;

   // a stalled response keeps its data
   `MAU_ASSERT_NEXT(a_rsp_hold, clock, reset, rv_ff && rsp_stall, rv_ff && $stable(out_res_ff), "response changed under stall")
   // a response stays below the effective modulus, unless that modulus is 1
   `MAU_ASSERT_IMPL(a_res_range, clock, reset, rv_ff, out_res_ff < m_eff || m_eff == DATA_WIDTH'(1), "result out of range")
   // flags are exclusive: compare flags never with divide flag, equal never with less
   `MAU_ASSERT_IMPL(a_flags, clock, reset, rv_ff, !(out_dz_ff && (out_eq_ff || out_lt_ff)) && !(out_eq_ff && out_lt_ff), "inconsistent flags")

endmodule
